// File: rtl/core/bcpc_pkg.sv
// types, codes and constants shared by the click pattern classifier
`timescale 1ns / 1ps
package bcpc_pkg;

    localparam int MAX_CLICKS = 3;
    localparam int NSLOTS     = MAX_CLICKS + 1;
    localparam int SLOT_IW    = $clog2(NSLOTS);

    localparam int TICK_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int IDATA_W = 32;
    localparam int ODATA_W = 8;

    typedef enum logic [1:0] {
        REQ_PRESS   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_POLL    = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        SLOT_REL   = 2'd0,
        SLOT_CLICK = 2'd1,
        SLOT_LONG  = 2'd2,
        SLOT_VLONG = 2'd3
    } t_slot;

    typedef enum logic [2:0] {
        RES_RELEASED   = 3'd0,
        RES_PROCESSING = 3'd1,
        RES_CLICK      = 3'd2,
        RES_LONG       = 3'd3,
        RES_VLONG      = 3'd4,
        RES_DOUBLE     = 3'd5,
        RES_TRIPLE     = 3'd6,
        RES_UNKNOWN    = 3'd7
    } t_click_res;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MIN_PAUSE      = 3'd0,
        CFG_CLICK_MIN      = 3'd1,
        CFG_LONG_MIN       = 3'd2,
        CFG_VERY_LONG_MIN  = 3'd3,
        CFG_SOFT_RESET_MIN = 3'd4,
        CFG_MAX_PAUSE      = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [CFG_W-1:0] min_pause;
        logic [CFG_W-1:0] click_min;
        logic [CFG_W-1:0] long_min;
        logic [CFG_W-1:0] very_long_min;
        logic [CFG_W-1:0] soft_reset_min;
        logic [CFG_W-1:0] max_pause;
    } t_cfg;

    typedef struct packed {
        logic       result_valid;
        t_click_res click_result;
        logic       reset_request;
    } t_res;

endpackage

// File: rtl/core/bcpc_cfg.sv
// configuration register file
`timescale 1ns / 1ps
module bcpc_cfg
    import bcpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MIN_PAUSE:      n_cfg.min_pause      = i_cfg_data;
                CFG_CLICK_MIN:      n_cfg.click_min      = i_cfg_data;
                CFG_LONG_MIN:       n_cfg.long_min       = i_cfg_data;
                CFG_VERY_LONG_MIN:  n_cfg.very_long_min  = i_cfg_data;
                CFG_SOFT_RESET_MIN: n_cfg.soft_reset_min = i_cfg_data;
                CFG_MAX_PAUSE:      n_cfg.max_pause      = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pause      <= CFG_W'(50);
            r_cfg.click_min      <= CFG_W'(50);
            r_cfg.long_min       <= CFG_W'(800);
            r_cfg.very_long_min  <= CFG_W'(2000);
            r_cfg.soft_reset_min <= CFG_W'(8000);
            r_cfg.max_pause      <= CFG_W'(400);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/core/bcpc_step.sv
// edge debounce, duration classification, slot store and pattern match
`timescale 1ns / 1ps
module bcpc_step
    import bcpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_fire,
    input  logic [1:0]        i_req_type,
    input  logic [TICK_W-1:0] i_now_tick,
    output t_res              o_res
);

    logic [TICK_W-1:0]  r_press_time;
    logic [TICK_W-1:0]  r_release_time;
    t_slot              r_slots [NSLOTS];
    logic [SLOT_IW-1:0] r_count;

    logic [TICK_W-1:0]  n_press_time;
    logic [TICK_W-1:0]  n_release_time;
    t_slot              n_slots [NSLOTS];
    logic [SLOT_IW-1:0] n_count;

    logic [TICK_W-1:0] dur;
    logic [TICK_W-1:0] since_rel;
    logic              gap_ok;
    t_slot             code;
    t_click_res        match;
    t_res              res;

    assign dur       = i_now_tick - r_press_time;
    assign since_rel = i_now_tick - r_release_time;
    assign gap_ok    = since_rel >= TICK_W'(i_cfg.min_pause);

    always_comb begin
        if (dur < TICK_W'(i_cfg.long_min)) begin
            code = SLOT_CLICK;
        end else if (dur < TICK_W'(i_cfg.very_long_min)) begin
            code = SLOT_LONG;
        end else if (dur < TICK_W'(i_cfg.soft_reset_min)) begin
            code = SLOT_VLONG;
        end else begin
            code = SLOT_REL;
        end
    end

    always_comb begin
        if (r_slots[0] == SLOT_CLICK && r_slots[1] == SLOT_REL) begin
            match = RES_CLICK;
        end else if (r_slots[0] == SLOT_LONG && r_slots[1] == SLOT_REL) begin
            match = RES_LONG;
        end else if (r_slots[0] == SLOT_VLONG && r_slots[1] == SLOT_REL) begin
            match = RES_VLONG;
        end else if (r_slots[0] == SLOT_CLICK && r_slots[1] == SLOT_CLICK
                     && r_slots[2] == SLOT_REL) begin
            match = RES_DOUBLE;
        end else if (r_slots[0] == SLOT_CLICK && r_slots[1] == SLOT_CLICK
                     && r_slots[2] == SLOT_CLICK && r_slots[3] == SLOT_REL) begin
            match = RES_TRIPLE;
        end else begin
            match = RES_UNKNOWN;
        end
    end

    always_comb begin
        n_press_time   = r_press_time;
        n_release_time = r_release_time;
        n_slots        = r_slots;
        n_count        = r_count;
        res            = '{result_valid: 1'b0, click_result: RES_RELEASED,
                           reset_request: 1'b0};
        case (t_req_type'(i_req_type))
            REQ_PRESS: begin
                if (dur >= TICK_W'(i_cfg.min_pause) && gap_ok) begin
                    n_press_time = i_now_tick;
                end
            end
            REQ_RELEASE: begin
                if (gap_ok && r_press_time != '0
                    && dur >= TICK_W'(i_cfg.click_min)) begin
                    n_release_time = i_now_tick;
                    if (r_count < SLOT_IW'(MAX_CLICKS)) begin
                        if (code != SLOT_REL) begin
                            n_slots[r_count] = code;
                            n_count          = r_count + 1'b1;
                        end else begin
                            res.reset_request = 1'b1;
                        end
                    end
                end
            end
            REQ_POLL: begin
                res.result_valid = 1'b1;
                if (r_release_time < r_press_time) begin
                    res.click_result = RES_PROCESSING;
                end else if (r_count == '0) begin
                    res.click_result = RES_RELEASED;
                end else if (since_rel < TICK_W'(i_cfg.max_pause)) begin
                    res.click_result = RES_PROCESSING;
                end else begin
                    res.click_result = match;
                    for (int i = 0; i < NSLOTS; i++) begin
                        n_slots[i] = SLOT_REL;
                    end
                    n_count = '0;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_time   <= '0;
            r_release_time <= '0;
            r_count        <= '0;
            for (int i = 0; i < NSLOTS; i++) begin
                r_slots[i] <= SLOT_REL;
            end
        end else if (i_fire) begin
            r_press_time   <= n_press_time;
            r_release_time <= n_release_time;
            r_count        <= n_count;
            r_slots        <= n_slots;
        end
    end

endmodule

// File: rtl/core/bcpc_out.sv
// result register toward the output stream
`timescale 1ns / 1ps
module bcpc_out
    import bcpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_res               i_res,
    output logic               o_free,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [ODATA_W-1:0] o_m_axis_tdata,
    output logic [0:0]         o_m_axis_tuser
);

    logic r_valid;
    logic n_valid;
    t_res r_res;

    assign o_free = !r_valid || i_m_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {4'b0000, r_res.reset_request, r_res.click_result};
    assign o_m_axis_tuser  = r_res.result_valid;

endmodule

// File: rtl/core/button_click_pattern_classifier.sv
// top level of the button click pattern classifier
`timescale 1ns / 1ps
// Takes one timestamped press, release or poll transfer per clock and returns
// exactly one result transfer for each, in order. An input transfer lands in
// an input register; once the output side is free, the debounce, duration
// classification, slot store update and pattern match run in one pass and
// the result is loaded into the output register. Sustained throughput is one
// item per cycle, limited only by the output side taking results.
// Configuration writes are always accepted and should be made while no item
// is in flight.
module button_click_pattern_classifier
    import bcpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [IDATA_W-1:0] i_s_axis_tdata,  // [31:0] now_tick
    input  logic [1:0]         i_s_axis_tuser,  // [1:0] req_type
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [ODATA_W-1:0] o_m_axis_tdata,  // [2:0] click_result, [3] reset_request
    output logic [0:0]         o_m_axis_tuser,  // [0] result_valid
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    t_cfg              cfg;
    t_res              res;
    logic              out_free;
    logic              advance;
    logic              r_in_valid;
    logic              n_in_valid;
    logic [1:0]        r_req_type;
    logic [TICK_W-1:0] r_now_tick;

    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_req_type <= i_s_axis_tuser;
            r_now_tick <= i_s_axis_tdata;
        end
    end

    bcpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bcpc_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_fire     (advance),
        .i_req_type (r_req_type),
        .i_now_tick (r_now_tick),
        .o_res      (res)
    );

    bcpc_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (advance),
        .i_res           (res),
        .o_free          (out_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
